>>> sv/plb_pkg.sv
package plb_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_DIM_DEF         = 4096;

    localparam int OFFSET_W     = 27;
    localparam int COLOUR_W     = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 15;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 64;

    // Queue between the front and the back; a power of two.
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_RECT_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_MODE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_PITCH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_LEFT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_TOP   = 3'd5;

    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    typedef struct packed {
        logic [12:0] rect_width;
        logic [12:0] rect_height;
        logic [1:0]  depth_mode;
        logic [14:0] target_pitch;
        logic [11:0] target_left;
        logic [11:0] target_top;
    } cfg_t;

    // One pixel on its way from the front to the back.
    typedef struct packed {
        logic [OFFSET_W-1:0] row_base;
        logic [OFFSET_W-1:0] col_bytes;
        logic [7:0]          pixel_value;
        logic                idx_ok;
        logic [COLOUR_W-1:0] colour;
        logic                row_end;
        logic                rect_end;
    } plb_entry_t;

endpackage

>>> sv/plb_front.sv
module plb_front
    import plb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int MAX_DIM         = MAX_DIM_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                  push,
    output plb_entry_t            push_entry
);

    localparam int AW   = $clog2(PALETTE_ENTRIES);
    localparam int CNTW = $clog2(MAX_DIM);
    localparam int DW   = CNTW + 1;
    localparam int CW   = (DW > 13) ? DW : 13;
    localparam logic [8:0]    PE_LIM  = 9'(PALETTE_ENTRIES);
    localparam logic [CW-1:0] DIM_LIM = CW'(MAX_DIM);

    logic [COLOUR_W-1:0] mem [PALETTE_ENTRIES];
    logic [COLOUR_W-1:0] rd_data_reg;

    logic [CNTW-1:0]     col_reg, col_next;
    logic [CNTW-1:0]     row_reg, row_next;
    logic [OFFSET_W-1:0] row_base_reg, row_base_next;
    logic                s1_valid_reg;
    plb_entry_t          s1_reg;

    logic [7:0]          slot;
    logic [COLOUR_W-1:0] colour;
    logic [7:0]          pix;
    logic                accept, acc_pal, acc_pix;
    logic                slot_ok, idx_ok;
    logic [CW-1:0]       rw, rh, w, h;
    logic                last_col, last_row;
    logic [OFFSET_W-1:0] colx, col_bytes;
    logic [FIFO_CNT_W:0] used;

    assign slot   = s_tdata[7:0];
    assign colour = s_tdata[39:8];
    assign pix    = s_tdata[47:40];

    // Credit check: the stage register always drains into the queue next cycle.
    assign used     = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_valid_reg);
    assign s_tready = used < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign acc_pal  = accept && (s_tuser == REQ_PALETTE);
    assign acc_pix  = accept && (s_tuser == REQ_PIXEL);

    assign slot_ok = {1'b0, slot} < PE_LIM;
    assign idx_ok  = {1'b0, pix} < PE_LIM;

    always_comb begin
        rw = CW'(cfg.rect_width);
        rh = CW'(cfg.rect_height);
        if (rw == '0) begin
            w = CW'(1);
        end else if (rw > DIM_LIM) begin
            w = DIM_LIM;
        end else begin
            w = rw;
        end
        if (rh == '0) begin
            h = CW'(1);
        end else if (rh > DIM_LIM) begin
            h = DIM_LIM;
        end else begin
            h = rh;
        end
    end

    assign last_col = (CW'(col_reg) + CW'(1)) >= w;
    assign last_row = last_col && ((CW'(row_reg) + CW'(1)) >= h);

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (acc_pix) begin
            if (!last_col) begin
                col_next = col_reg + 1'b1;
            end else if (!last_row) begin
                col_next      = '0;
                row_next      = row_reg + 1'b1;
                row_base_next = row_base_reg + OFFSET_W'(cfg.target_pitch);
            end else begin
                col_next      = '0;
                row_next      = '0;
                row_base_next = '0;
            end
        end
    end

    assign colx = OFFSET_W'(cfg.target_left) + OFFSET_W'(col_reg);

    always_comb begin
        case (cfg.depth_mode)
            DEPTH_8:  col_bytes = colx;
            DEPTH_16: col_bytes = colx << 1;
            DEPTH_24: col_bytes = colx + (colx << 1);
            DEPTH_32: col_bytes = colx << 2;
            default:  col_bytes = colx;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_pal && slot_ok) begin
            mem[slot[AW-1:0]] <= colour;
        end
        if (acc_pix) begin
            rd_data_reg <= mem[pix[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            s1_valid_reg <= acc_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_pix) begin
            s1_reg.row_base    <= row_base_reg;
            s1_reg.col_bytes   <= col_bytes;
            s1_reg.pixel_value <= pix;
            s1_reg.idx_ok      <= idx_ok;
            s1_reg.colour      <= '0;
            s1_reg.row_end     <= last_col;
            s1_reg.rect_end    <= last_row;
        end
    end

    always_comb begin
        push_entry        = s1_reg;
        push_entry.colour = rd_data_reg;
    end

    assign push = s1_valid_reg;

endmodule

>>> sv/plb_fifo.sv
module plb_fifo
    import plb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  plb_entry_t            push_entry,
    input  logic                  pop,
    output plb_entry_t            head,
    output logic                  head_valid,
    output logic [FIFO_CNT_W-1:0] count
);

    plb_entry_t            slots [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = slots[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg < FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with unequal pointers");

endmodule

>>> sv/plb_back.sv
module plb_back
    import plb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  plb_entry_t           head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    logic [OFFSET_W-1:0]  base_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;
    logic                 m_user_reg;

    logic                 load;
    logic [OFFSET_W-1:0]  offset;
    logic [COLOUR_W-1:0]  entry;
    logic [COLOUR_W-1:0]  data;
    logic [2:0]           byte_count;

    // Origin row offset; user, not block, keeps config stable in flight.
    always_ff @(posedge aclk) begin
        base_reg <= OFFSET_W'(cfg.target_pitch) * OFFSET_W'(cfg.target_top);
    end

    assign load = head_valid && (!m_valid_reg || m_tready);
    assign pop  = load;

    assign offset     = base_reg + head.row_base + head.col_bytes;
    assign entry      = head.idx_ok ? head.colour : '0;
    assign byte_count = {1'b0, cfg.depth_mode} + 3'd1;

    always_comb begin
        case (cfg.depth_mode)
            DEPTH_8:  data = {24'd0, head.pixel_value};
            DEPTH_16: data = {16'd0, entry[15:0]};
            DEPTH_24: data = {8'd0, entry[23:0]};
            DEPTH_32: data = entry;
            default:  data = entry;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= {2'b00, byte_count, data, offset};
            m_last_reg <= head.row_end;
            m_user_reg <= head.rect_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> sv/palette_lookup_blitter.sv
// Rectangle blitter with palette translation.
// Input channel s_*: s_tuser selects the item kind. A palette write (s_tuser
// low) stores a 32-bit colour into one table entry and gives no result. A
// pixel item (s_tuser high) carries one 8-bit source index, in raster order
// of the rectangle, and gives exactly one result on m_*.
// Result: byte offset in the target buffer, pixel bytes (little-endian, a
// copy of the index in 8-bit mode, else the low bytes of the palette entry)
// and the byte count. m_tlast marks the last pixel of a row, m_tuser the
// last pixel of the rectangle; the counters then return to the origin.
// Throughput is one item per clock while m_tready keeps the output moving. A
// result passes the registered palette read in the stage register, the queue,
// and the offset sum into the output register.
// A four-entry queue sits between the lookup front and the output back.
// When m_tready is low the queue fills and s_tready drops once the queue and the stage register hold four items.
// Reset clears the counters, the queue and the config to their defaults;
// palette contents are undefined until written and need no clearing.
// Config may be written only while no item is in flight.
module palette_lookup_blitter
    import plb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int MAX_DIM         = MAX_DIM_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // palette_slot[7:0], palette_colour[39:8], pixel_value[47:40]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_offset[26:0], pixel_data[58:27], byte_count[61:59], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // row_end
    output logic                  m_tlast,
    // rect_end
    output logic                  m_tuser
);

    cfg_t cfg_reg, cfg_next;

    logic                  push;
    plb_entry_t            push_entry;
    logic                  pop;
    plb_entry_t            head;
    logic                  head_valid;
    logic [FIFO_CNT_W-1:0] fifo_count;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RECT_WIDTH:   cfg_next.rect_width   = cfg_wr_data[12:0];
                REG_RECT_HEIGHT:  cfg_next.rect_height  = cfg_wr_data[12:0];
                REG_DEPTH_MODE:   cfg_next.depth_mode   = cfg_wr_data[1:0];
                REG_TARGET_PITCH: cfg_next.target_pitch = cfg_wr_data[14:0];
                REG_TARGET_LEFT:  cfg_next.target_left  = cfg_wr_data[11:0];
                REG_TARGET_TOP:   cfg_next.target_top   = cfg_wr_data[11:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rect_width   <= 13'd1;
            cfg_reg.rect_height  <= 13'd1;
            cfg_reg.depth_mode   <= DEPTH_8;
            cfg_reg.target_pitch <= '0;
            cfg_reg.target_left  <= '0;
            cfg_reg.target_top   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    plb_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_DIM         (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_count (fifo_count),
        .push       (push),
        .push_entry (push_entry)
    );

    plb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (fifo_count)
    );

    plb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
